// File: rtl/tcpr_pkg.sv
// ----------------------------------------------------------------------------
// tcpr_pkg
// Shared types and result codes for the TCP segment reorder tracker.
// ----------------------------------------------------------------------------
package tcpr_pkg;

  typedef logic [2:0] status_t;

  localparam status_t ST_RELEASED  = 3'd0;
  localparam status_t ST_HELD      = 3'd1;
  localparam status_t ST_DUPLICATE = 3'd2;
  localparam status_t ST_POOL_FULL = 3'd3;
  localparam status_t ST_UNKNOWN   = 3'd4;
  localparam status_t ST_TABLE_FULL = 3'd5;

  localparam int SEQ_W  = 32;
  localparam int LEN_W  = 16;
  localparam int PORT_W = 16;

endpackage

// File: rtl/tcpr_ram.sv
// ----------------------------------------------------------------------------
// tcpr_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module tcpr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/tcp_segment_reorder_tracker_unit.sv
// ----------------------------------------------------------------------------
// tcp_segment_reorder_tracker_unit
// Tracks client flows by port and puts server response segments back in order.
// ----------------------------------------------------------------------------
// A request or a dropped unknown-flow item goes from S_LOOK to S_EMIT; a
// response passes S_LOOK, S_FRD, S_SCAN (one pool RAM read per slot), S_SEND
// and S_DECIDE before its first result, and each drained held segment
// rescans the pool. One item is in work at a time; the next is taken after the
// final result of the current one is loaded into the output register.
// Reset clears flow and slot valid bits at once; RAM contents stay undefined.
// ----------------------------------------------------------------------------
module tcp_segment_reorder_tracker_unit
  import tcpr_pkg::*;
#(
  parameter int FLOWS    = 8,
  parameter int SLOTS    = 16,
  parameter int TAG_BITS = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        direction,
  input  logic [15:0] flow_port,
  input  logic [31:0] seq_number,
  input  logic [31:0] ack_number,
  input  logic [15:0] payload_len,
  input  logic [7:0]  buffer_tag,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_port,
  output logic [7:0]  out_tag,
  output logic        out_direction,
  output logic [31:0] out_rel_seq,
  output logic [15:0] out_len,
  output logic [2:0]  status,
  output logic        last
);

  localparam int FW  = (FLOWS > 1) ? $clog2(FLOWS) : 1;
  localparam int SW  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int FRW = 2 * SEQ_W;
  localparam int PW  = SEQ_W + LEN_W + TAG_BITS;

  typedef enum logic [2:0] {
    S_IDLE, S_LOOK, S_FRD, S_SCAN, S_SEND, S_DECIDE, S_EMIT
  } state_t;

  state_t state;

  // latched item
  logic                i_dir;
  logic [PORT_W-1:0]   i_port;
  logic [SEQ_W-1:0]    i_seq;
  logic [SEQ_W-1:0]    i_ack;
  logic [LEN_W-1:0]    i_len;
  logic [TAG_BITS-1:0] i_tag;

  // flow table tags in flops, offsets in RAM
  logic              flow_vld [FLOWS];
  logic [PORT_W-1:0] flow_prt [FLOWS];
  logic              slot_vld [SLOTS];
  logic [FW-1:0]     slot_flow [SLOTS];

  logic [FW-1:0]    cur_flow;
  logic [SEQ_W-1:0] ack_off;
  logic [SEQ_W-1:0] nexp;
  logic             drain;
  logic             dup;
  logic             found;
  logic [SEQ_W-1:0] low_rel;
  logic [LEN_W-1:0] low_len;
  logic [TAG_BITS-1:0] low_tag;
  logic [SW-1:0]    low_slot;
  logic [SW-1:0]    scan_idx;
  logic             rd_pend;
  logic [SW-1:0]    rd_slot;

  // pending result
  logic [TAG_BITS-1:0] pend_tag;
  logic [SEQ_W-1:0]    pend_rel;
  logic [LEN_W-1:0]    pend_len;
  status_t             pend_status;
  logic                pend_last;

  // lookups
  logic          hit, free_hit, slot_free_hit;
  logic [FW-1:0] hit_idx, free_idx, new_idx;
  logic [SW-1:0] free_slot;

  always_comb begin
    hit = 1'b0;
    hit_idx = '0;
    free_hit = 1'b0;
    free_idx = '0;
    for (int i = FLOWS - 1; i >= 0; i--) begin
      if (flow_vld[i] && flow_prt[i] == i_port) begin
        hit = 1'b1;
        hit_idx = FW'(i);
      end
      if (!flow_vld[i]) begin
        free_hit = 1'b1;
        free_idx = FW'(i);
      end
    end
    new_idx = hit ? hit_idx : free_idx;
    slot_free_hit = 1'b0;
    free_slot = '0;
    for (int s = SLOTS - 1; s >= 0; s--) begin
      if (!slot_vld[s]) begin
        slot_free_hit = 1'b1;
        free_slot = SW'(s);
      end
    end
  end

  // flow RAM: {ack offset, next expected}
  logic           frm_we;
  logic [FW-1:0]  frm_waddr;
  logic [FRW-1:0] frm_wdata;
  logic [FRW-1:0] frm_rdata;

  // pool RAM: {rel seq, len, tag}
  logic          prm_we;
  logic [PW-1:0] prm_wdata;
  logic [PW-1:0] prm_rdata;

  logic drain_go;
  assign drain_go = found && (low_rel == nexp);

  always_comb begin
    frm_we = 1'b0;
    frm_waddr = cur_flow;
    frm_wdata = {ack_off, nexp};
    if (state == S_LOOK && !i_dir && (hit || free_hit)) begin
      frm_we = 1'b1;
      frm_waddr = new_idx;
      frm_wdata = {i_ack, SEQ_W'(1)};
    end else if (state == S_DECIDE && drain && !drain_go) begin
      frm_we = 1'b1;
    end
  end

  assign prm_we    = (state == S_DECIDE) && !drain && !dup && slot_free_hit;
  assign prm_wdata = {pend_rel, pend_len, pend_tag};

  tcpr_ram #(.WIDTH(FRW), .DEPTH(FLOWS)) u_flow_ram (
    .clk   (clk),
    .we    (frm_we),
    .waddr (frm_waddr),
    .wdata (frm_wdata),
    .raddr (hit_idx),
    .rdata (frm_rdata)
  );

  tcpr_ram #(.WIDTH(PW), .DEPTH(SLOTS)) u_pool_ram (
    .clk   (clk),
    .we    (prm_we),
    .waddr (free_slot),
    .wdata (prm_wdata),
    .raddr (scan_idx),
    .rdata (prm_rdata)
  );

  // scan read-back
  logic [SEQ_W-1:0]    rd_rel;
  logic [LEN_W-1:0]    rd_len;
  logic [TAG_BITS-1:0] rd_tag;
  logic                rd_own;
  logic [SEQ_W-1:0]    rel_calc;

  assign rd_rel   = prm_rdata[PW-1 -: SEQ_W];
  assign rd_len   = prm_rdata[TAG_BITS +: LEN_W];
  assign rd_tag   = prm_rdata[TAG_BITS-1:0];
  assign rd_own   = rd_pend && slot_vld[rd_slot] && (slot_flow[rd_slot] == cur_flow);
  assign rel_calc = i_seq - frm_rdata[FRW-1 -: SEQ_W] + SEQ_W'(1);

  logic out_free;
  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      rd_pend   <= 1'b0;
      for (int i = 0; i < FLOWS; i++) flow_vld[i] <= 1'b0;
      for (int s = 0; s < SLOTS; s++) slot_vld[s] <= 1'b0;
    end else begin
      // drop the output item once taken, unless a new one is loaded below
      if (out_valid && !out_stall && state != S_EMIT) out_valid <= 1'b0;

      // one pool read in flight per scan step
      rd_pend <= (state == S_SCAN);
      rd_slot <= scan_idx;
      if (rd_own) begin
        if (rd_rel == pend_rel) dup <= 1'b1;
        if (!found || rd_rel < low_rel) begin
          found    <= 1'b1;
          low_rel  <= rd_rel;
          low_len  <= rd_len;
          low_tag  <= rd_tag;
          low_slot <= rd_slot;
        end
      end

      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            i_dir  <= direction;
            i_port <= flow_port;
            i_seq  <= seq_number;
            i_ack  <= ack_number;
            i_len  <= payload_len;
            i_tag  <= TAG_BITS'(buffer_tag);
            state  <= S_LOOK;
          end
        end
        S_LOOK: begin
          pend_tag  <= i_tag;
          pend_len  <= i_len;
          pend_last <= 1'b1;
          cur_flow  <= i_dir ? hit_idx : new_idx;
          if (!i_dir) begin
            if (hit || free_hit) begin
              // open or reset the flow and drop its held segments
              flow_vld[new_idx] <= 1'b1;
              flow_prt[new_idx] <= i_port;
              for (int s = 0; s < SLOTS; s++) begin
                if (slot_flow[s] == new_idx) slot_vld[s] <= 1'b0;
              end
              pend_rel    <= SEQ_W'(1);
              pend_status <= ST_RELEASED;
            end else begin
              pend_rel    <= '0;
              pend_status <= ST_TABLE_FULL;
            end
            state <= S_EMIT;
          end else if (!hit) begin
            pend_rel    <= '0;
            pend_status <= ST_UNKNOWN;
            state       <= S_EMIT;
          end else begin
            state <= S_FRD;
          end
        end
        S_FRD: begin
          ack_off  <= frm_rdata[FRW-1 -: SEQ_W];
          pend_rel <= rel_calc;
          if (rel_calc == frm_rdata[SEQ_W-1:0]) begin
            drain <= 1'b1;
            nexp  <= frm_rdata[SEQ_W-1:0] + SEQ_W'(i_len);
          end else begin
            drain <= 1'b0;
            nexp  <= frm_rdata[SEQ_W-1:0];
          end
          pend_status <= ST_RELEASED;
          scan_idx    <= '0;
          dup         <= 1'b0;
          found       <= 1'b0;
          state       <= S_SCAN;
        end
        S_SCAN: begin
          if (scan_idx == SW'(SLOTS - 1)) begin
            state <= S_SEND;
          end else begin
            scan_idx <= scan_idx + SW'(1);
          end
        end
        S_SEND: begin
          state <= S_DECIDE;
        end
        S_DECIDE: begin
          if (drain) begin
            pend_last <= !drain_go;
          end else begin
            pend_last <= 1'b1;
            if (dup) begin
              pend_status <= ST_DUPLICATE;
            end else if (!slot_free_hit) begin
              pend_status <= ST_POOL_FULL;
            end else begin
              pend_status          <= ST_HELD;
              slot_vld[free_slot]  <= 1'b1;
              slot_flow[free_slot] <= cur_flow;
            end
          end
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (out_free) begin
            out_valid     <= 1'b1;
            out_port      <= i_port;
            out_tag       <= 8'(pend_tag);
            out_direction <= i_dir;
            out_rel_seq   <= pend_rel;
            out_len       <= pend_len;
            status        <= pend_status;
            last          <= pend_last;
            if (pend_last) begin
              state <= S_IDLE;
            end else begin
              // advance to the drained segment and rescan the pool
              pend_tag           <= low_tag;
              pend_rel           <= low_rel;
              pend_len           <= low_len;
              pend_status        <= ST_RELEASED;
              slot_vld[low_slot] <= 1'b0;
              nexp               <= nexp + SEQ_W'(low_len);
              scan_idx           <= '0;
              found              <= 1'b0;
              dup                <= 1'b0;
              state              <= S_SCAN;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_accept_look: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> (state == S_LOOK))
    else $error("accepted item did not start a flow lookup");

  a_flow_wr_state: assert property (@(posedge clk) disable iff (rst)
    frm_we |-> (state == S_LOOK || state == S_DECIDE))
    else $error("flow RAM written outside lookup or decide");

  a_pool_wr_free: assert property (@(posedge clk) disable iff (rst)
    prm_we |-> !slot_vld[free_slot])
    else $error("pool write into an occupied slot");

endmodule
